FILE: src/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants for the sorted table search block
// Payload structs, opcodes, register indexes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sts_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int INDEX_WIDTH = 6;
   localparam int COUNT_WIDTH = 7;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH = 7;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam logic METHOD_LINEAR = 1'b0;
   localparam logic METHOD_BINARY = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ENTRY_COUNT   = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEARCH_METHOD = 1'b1;

   typedef struct packed {
      logic                          op;
      logic [INDEX_WIDTH-1:0]        entry_index;
      logic signed [VALUE_WIDTH-1:0] data_value;
   } req_type;

   typedef struct packed {
      logic                   found;
      logic [INDEX_WIDTH-1:0] match_index;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LSCAN,
      ST_BPROBE,
      ST_BCHECK
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic store;       // write the request's entry into the table
      logic load;        // capture key and set up a search
      logic lin_step;    // issue next linear read, shift pending compare
      logic bin_probe;   // read at the midpoint
      logic bin_update;  // narrow the bounds after a miss
      logic finish;      // post a result beat
      logic hit;         // result is a match
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic lin_hit;
      logic lin_end;
      logic bin_empty;
      logic bin_hit;
   } status_type;

endpackage

FILE: src/sorted_table_search.sv
// ----------------------------------------------------------------------------
// sorted_table_search: table of signed words with linear or binary key search
// Write beats fill the table by index; search beats return found and index.
// ----------------------------------------------------------------------------
// Usage: raise start with a beat on req_payload; it is taken at an edge where
// busy is low. A write beat (op = 0) stores data_value at entry_index and
// gives no result; busy stays low, so the next beat may follow at once. A
// search beat (op = 1) raises busy until its result is posted. The result
// shows on rsp_payload for exactly one cycle, marked by rsp_valid; there is
// no back-pressure, so the receiver must capture it in that cycle. Busy drops
// in the same cycle the result appears, so a new beat can be taken then.
// The table memory has a single read port and a registered read. A linear
// search reads the entries in index order and ends at the first match or
// after entry_count entries; a binary search makes a probe at each
// midpoint (address, then compare) until a hit or until the bounds cross.
// Write the csr registers only while no search is in flight. Binary mode
// expects the first entry_count entries written in ascending order; search
// only entries that were written.
// ----------------------------------------------------------------------------
module sorted_table_search #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  sts_pkg::req_type                     req_payload,
   output logic                                 rsp_valid,
   output sts_pkg::rsp_type                     rsp_payload,
   input  logic                                 csr_we,
   input  logic [sts_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [sts_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   import sts_pkg::*;

   logic [COUNT_WIDTH-1:0] entry_count_ff, entry_count_in;
   logic                   search_method_ff, search_method_in;

   cmd_type    cmd;
   status_type status;

   // register decode; hold the other register on each write
   always_comb begin
      entry_count_in   = entry_count_ff;
      search_method_in = search_method_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ENTRY_COUNT: begin
               entry_count_in = csr_wdata[COUNT_WIDTH-1:0];
            end
            CSR_SEARCH_METHOD: begin
               search_method_in = csr_wdata[0];
            end
            default: begin
               entry_count_in = entry_count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff   <= '0;
         search_method_ff <= METHOD_LINEAR;
      end else begin
         entry_count_ff   <= entry_count_in;
         search_method_ff <= search_method_in;
      end
   end

   // sequencer: picks the search loop and steps it
   sts_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_op  (req_payload.op),
      .method  (search_method_ff),
      .status  (status),
      .cmd     (cmd),
      .busy    (busy)
   );

   // table memory, key and bounds, result register
   sts_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .entry_count (entry_count_ff),
      .method      (search_method_ff),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: src/sts_ram.sv
// ----------------------------------------------------------------------------
// sts_ram: generic single-write, single-read memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/sts_ctrl.sv
// ----------------------------------------------------------------------------
// sts_ctrl: search sequencer
// Steps the linear scan or the binary probe loop and posts the result.
// ----------------------------------------------------------------------------
module sts_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_op,
   input  logic                method,
   input  sts_pkg::status_type status,
   output sts_pkg::cmd_type    cmd,
   output logic                busy
);

   import sts_pkg::*;

   state_type state_ff;
   state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && req_op == OP_SEARCH) begin
               state_in = (method == METHOD_BINARY) ? ST_BPROBE : ST_LSCAN;
            end
         end
         ST_LSCAN: begin
            if (status.lin_hit || status.lin_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_BPROBE: begin
            state_in = status.bin_empty ? ST_IDLE : ST_BCHECK;
         end
         ST_BCHECK: begin
            state_in = status.bin_hit ? ST_IDLE : ST_BPROBE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy      = 1'b0;
            cmd.store = start && req_op == OP_WRITE;
            cmd.load  = start && req_op == OP_SEARCH;
         end
         ST_LSCAN: begin
            cmd.lin_step = 1'b1;
            cmd.finish   = status.lin_hit || status.lin_end;
            cmd.hit      = status.lin_hit;
         end
         ST_BPROBE: begin
            cmd.bin_probe = !status.bin_empty;
            cmd.finish    = status.bin_empty;
         end
         ST_BCHECK: begin
            cmd.bin_update = !status.bin_hit;
            cmd.finish     = status.bin_hit;
            cmd.hit        = status.bin_hit;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/sts_dpath.sv
// ----------------------------------------------------------------------------
// sts_dpath: table, search registers and result register
// Holds the key, scan pointer, binary bounds and the table memory.
// ----------------------------------------------------------------------------
module sts_dpath #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sts_pkg::req_type                    req_payload,
   input  logic [sts_pkg::COUNT_WIDTH-1:0]     entry_count,
   input  logic                                method,
   input  sts_pkg::cmd_type                    cmd,
   output sts_pkg::status_type                 status,
   output logic                                rsp_valid,
   output sts_pkg::rsp_type                    rsp_payload
);

   import sts_pkg::*;

   localparam int ADDR_WIDTH = $clog2(TABLE_DEPTH);

   logic signed [VALUE_WIDTH-1:0] key_ff, key_in;
   logic [COUNT_WIDTH-1:0]        count_ff, count_in;
   logic                          method_ff, method_in;
   logic [COUNT_WIDTH-1:0]        issue_ff, issue_in;
   logic [COUNT_WIDTH-1:0]        pend_idx_ff, pend_idx_in;
   logic                          pend_v_ff, pend_v_in;
   logic signed [COUNT_WIDTH:0]   lo_ff, lo_in;
   logic signed [COUNT_WIDTH:0]   hi_ff, hi_in;
   logic [COUNT_WIDTH-1:0]        mid_ff, mid_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_type                       rsp_ff, rsp_in;

   logic [COUNT_WIDTH-1:0]        count_sat;
   logic [COUNT_WIDTH+1:0]        mid_sum;
   logic [COUNT_WIDTH-1:0]        mid;
   logic                          issue_more;
   logic                          key_eq;
   logic                          key_gt;
   logic [COUNT_WIDTH-1:0]        hit_idx;
   logic                          wr_en;
   logic [ADDR_WIDTH-1:0]         wr_addr;
   logic [ADDR_WIDTH-1:0]         rd_addr;
   logic [VALUE_WIDTH-1:0]        rd_data;

   // clamp the count to the table depth
   assign count_sat = (32'(entry_count) > TABLE_DEPTH) ? COUNT_WIDTH'(TABLE_DEPTH)
                                                       : entry_count;

   assign mid_sum    = (COUNT_WIDTH+2)'(lo_ff) + (COUNT_WIDTH+2)'(hi_ff);
   assign mid        = mid_sum[COUNT_WIDTH:1];
   assign issue_more = issue_ff < count_ff;
   assign key_eq     = $signed(rd_data) == key_ff;
   assign key_gt     = key_ff > $signed(rd_data);

   assign status.lin_hit   = pend_v_ff && key_eq;
   assign status.lin_end   = !pend_v_ff && !issue_more;
   assign status.bin_empty = lo_ff > hi_ff;
   assign status.bin_hit   = key_eq;

   // drop writes beyond the table
   assign wr_en   = cmd.store && (32'(req_payload.entry_index) < TABLE_DEPTH);
   assign wr_addr = ADDR_WIDTH'(req_payload.entry_index);
   assign rd_addr = cmd.bin_probe ? ADDR_WIDTH'(mid) : ADDR_WIDTH'(issue_ff);

   sts_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_payload.data_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign hit_idx = method_ff ? mid_ff : pend_idx_ff;

   always_comb begin
      key_in       = key_ff;
      count_in     = count_ff;
      method_in    = method_ff;
      issue_in     = issue_ff;
      pend_idx_in  = pend_idx_ff;
      pend_v_in    = pend_v_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      rsp_valid_in = cmd.finish;
      rsp_in       = rsp_ff;

      if (cmd.load) begin
         key_in    = req_payload.data_value;
         count_in  = count_sat;
         method_in = method;
         issue_in  = '0;
         pend_v_in = 1'b0;
         if (method == METHOD_BINARY) begin
            lo_in = '0;
            hi_in = $signed({1'b0, count_sat}) - (COUNT_WIDTH+1)'(1);
         end
      end

      // advance the scan pointer; the compare trails the registered read
      if (cmd.lin_step) begin
         pend_v_in   = issue_more;
         pend_idx_in = issue_ff;
         if (issue_more) begin
            issue_in = issue_ff + COUNT_WIDTH'(1);
         end
      end

      if (cmd.bin_probe) begin
         mid_in = mid;
      end

      if (cmd.bin_update) begin
         if (key_gt) begin
            lo_in = $signed({1'b0, mid_ff}) + (COUNT_WIDTH+1)'(1);
         end else begin
            hi_in = $signed({1'b0, mid_ff}) - (COUNT_WIDTH+1)'(1);
         end
      end

      if (cmd.finish) begin
         rsp_in.found       = cmd.hit;
         rsp_in.match_index = cmd.hit ? INDEX_WIDTH'(hit_idx) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lo_ff        <= '0;
         hi_ff        <= '0;
      end else begin
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      count_ff    <= count_in;
      method_ff   <= method_in;
      issue_ff    <= issue_in;
      pend_idx_ff <= pend_idx_in;
      mid_ff      <= mid_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: tb/search_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// search_result_checker: scoreboard for the sorted table search block
// Tracks table writes and register writes, predicts one result per search
// beat and compares each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module search_result_checker #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  sts_pkg::req_type                    req_payload,
   input  logic                                rsp_valid,
   input  sts_pkg::rsp_type                    rsp_payload,
   input  logic                                csr_we,
   input  logic [sts_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [sts_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                                  pending_results,
   output int                                  failure_count
);

   import sts_pkg::*;

   logic signed [VALUE_WIDTH-1:0] table_words [TABLE_DEPTH];
   logic [COUNT_WIDTH-1:0]        entry_count;
   logic                          search_method;
   rsp_type                       expected_matches [$];
   int                            mismatch_count = 0;

   function automatic rsp_type lookup_key(input logic signed [VALUE_WIDTH-1:0] key);
      rsp_type answer;
      int      count;
      int      lo;
      int      hi;
      int      mid;
      answer = '0;
      count  = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
      if (search_method == METHOD_LINEAR) begin
         for (int i = 0; i < count && !answer.found; i++) begin
            if (table_words[i] == key) begin
               answer.found       = 1'b1;
               answer.match_index = i[INDEX_WIDTH-1:0];
            end
         end
      end else begin
         lo = 0;
         hi = count - 1;
         while (lo <= hi && !answer.found) begin
            mid = (lo + hi) / 2;
            if (table_words[mid] == key) begin
               answer.found       = 1'b1;
               answer.match_index = mid[INDEX_WIDTH-1:0];
            end else if (key > table_words[mid]) begin
               lo = mid + 1;
            end else begin
               hi = mid - 1;
            end
         end
      end
      return answer;
   endfunction

   always @(posedge clock) begin : watch_channels
      rsp_type want;
      if (reset) begin
         expected_matches.delete();
         entry_count   = '0;
         search_method = METHOD_LINEAR;
         for (int i = 0; i < TABLE_DEPTH; i++) table_words[i] = '0;
      end else begin
         // compare first: a result and a new search can share an edge
         if (rsp_valid) begin
            if (expected_matches.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result beat found=%0b index=%0d",
                           $time, rsp_payload.found, rsp_payload.match_index);
            end else begin
               want = expected_matches.pop_front();
               if (rsp_payload.found !== want.found ||
                   rsp_payload.match_index !== want.match_index) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: mismatch exp found=%0b idx=%0d got found=%0b idx=%0d",
                              $time, want.found, want.match_index,
                              rsp_payload.found, rsp_payload.match_index);
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_ENTRY_COUNT:   entry_count   = csr_wdata[COUNT_WIDTH-1:0];
               CSR_SEARCH_METHOD: search_method = csr_wdata[0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (req_payload.op == OP_WRITE)
               table_words[req_payload.entry_index] = req_payload.data_value;
            else
               expected_matches.push_back(lookup_key(req_payload.data_value));
         end
      end
      pending_results <= expected_matches.size();
      failure_count   <= mismatch_count;
   end

endmodule

FILE: tb/tb_sorted_table_search.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_table_search: stimulus and verdict for the sorted table search
// Fills the table, switches count and method between phases, fires search
// beats with random gaps and lets the checker score every result beat.
// ----------------------------------------------------------------------------
module tb_sorted_table_search;
   import sts_pkg::*;

   localparam int TABLE_DEPTH    = 64;
   localparam int ITEM_TARGET    = 1100;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 80;   // longer than a full linear scan

   localparam logic signed [VALUE_WIDTH-1:0] WORD_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam logic signed [VALUE_WIDTH-1:0] WORD_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       start       = 1'b0;
   logic                       busy;
   req_type                    req_payload = '0;
   logic                       rsp_valid;
   rsp_type                    rsp_payload;
   logic                       csr_we      = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index   = CSR_ENTRY_COUNT;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata   = '0;

   int pending_results;
   int failure_count;

   // Stimulus-side copy of the table, used only to pick keys that hit.
   logic signed [VALUE_WIDTH-1:0] shadow_words [TABLE_DEPTH];
   bit  quiet_phase = 1'b0;   // phase with back-to-back beats, no gaps
   int  beats_sent  = 0;
   int  idle_cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   sorted_table_search #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   search_result_checker #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_payload    (rsp_payload),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .pending_results(pending_results),
      .failure_count  (failure_count)
   );

   // Watchdog: any accepted beat, result beat or register write resets the
   // count; a stuck handshake ends the run as a failure.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, no beat accepted for %0d cycles",
                  $time, WATCHDOG_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Mostly short gaps, a few long ones; none in a quiet phase.
   function automatic int next_gap();
      int roll;
      if (quiet_phase) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Small values collide often, which makes first-match scans interesting.
   function automatic logic signed [VALUE_WIDTH-1:0] random_word();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 6) return int'($urandom_range(0, 8)) - 4;
      if (roll == 6) return WORD_MIN;
      if (roll == 7) return WORD_MAX;
      return $urandom();
   endfunction

   // Prefer keys that sit in the active part of the table.
   function automatic logic signed [VALUE_WIDTH-1:0] pick_key(input int count_value);
      int active;
      int roll;
      logic signed [VALUE_WIDTH-1:0] hit_word;
      active = (count_value > TABLE_DEPTH) ? TABLE_DEPTH : count_value;
      roll   = $urandom_range(0, 9);
      if (active == 0 || roll > 6) return random_word();
      hit_word = shadow_words[$urandom_range(0, active - 1)];
      if (roll < 6) return hit_word;
      return $urandom_range(0, 1) ? hit_word + 1 : hit_word - 1;
   endfunction

   // Drive one beat and hold it until the block takes it. Start is only
   // dropped when a gap follows, so a back-to-back beat keeps it high.
   task automatic send_beat(input logic op, input logic [INDEX_WIDTH-1:0] index,
                            input logic signed [VALUE_WIDTH-1:0] value);
      int      gap;
      req_type beat;
      gap = next_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      beat.op          = op;
      beat.entry_index = index;
      beat.data_value  = value;
      req_payload <= beat;
      start       <= 1'b1;
      do @(posedge clock); while (busy);
      if (op == OP_WRITE) shadow_words[index] = value;
      beats_sent++;
   endtask

   task automatic store_word(input int index, input logic signed [VALUE_WIDTH-1:0] value);
      send_beat(OP_WRITE, index[INDEX_WIDTH-1:0], value);
   endtask

   // The index field is ignored on a search; randomize it anyway.
   task automatic find_word(input logic signed [VALUE_WIDTH-1:0] key);
      send_beat(OP_SEARCH, INDEX_WIDTH'($urandom_range(0, TABLE_DEPTH - 1)), key);
   endtask

   // Drop start, let every outstanding result land, then hold a few cycles
   // so no search is still in flight.
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Program both registers back to back while the block is quiet.
   task automatic set_mode(input int count_value, input logic method);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_ENTRY_COUNT;
      csr_wdata <= CSR_DATA_WIDTH'(count_value);
      @(posedge clock);
      csr_index <= CSR_SEARCH_METHOD;
      csr_wdata <= CSR_DATA_WIDTH'(method);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Write every entry a search can touch. Sorted fills walk upward with a
   // random step size and clamp at the top of the range.
   task automatic fill_table(input int count_value, input bit sorted);
      int     active;
      longint level;
      longint step_cap;
      bit     pin_top;
      active   = (count_value > TABLE_DEPTH) ? TABLE_DEPTH : count_value;
      level    = ($urandom_range(0, 3) == 0) ? longint'(WORD_MIN)
                                              : longint'($signed($urandom()));
      step_cap = ($urandom_range(0, 2) == 0) ? 2 :
                 ($urandom_range(0, 1) == 0) ? 1000 : (longint'(1) << 26);
      pin_top  = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < active; i++) begin
         if (sorted) begin
            if (i > 0) level = level + longint'($urandom_range(0, int'(step_cap)));
            if (level > longint'(WORD_MAX)) level = longint'(WORD_MAX);
            if (pin_top && i == active - 1) level = longint'(WORD_MAX);
            store_word(i, level[VALUE_WIDTH-1:0]);
         end else begin
            store_word(i, random_word());
         end
      end
   endtask

   initial begin
      int   count_value;
      int   roll;
      logic method;
      bit   sorted;

      for (int i = 0; i < TABLE_DEPTH; i++) shadow_words[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table in both methods
      set_mode(0, METHOD_LINEAR);
      find_word(0);
      find_word(-1);
      set_mode(0, METHOD_BINARY);
      find_word(WORD_MAX);

      // Directed: four entries with a duplicate and both range extremes
      set_mode(4, METHOD_LINEAR);
      store_word(0, WORD_MIN);
      store_word(1, 7);
      store_word(2, 7);
      store_word(3, WORD_MAX);
      find_word(7);          // first match wins
      find_word(WORD_MAX);
      find_word(WORD_MIN);
      find_word(8);          // miss
      set_mode(4, METHOD_BINARY);
      find_word(WORD_MIN);
      find_word(WORD_MAX);
      find_word(7);
      find_word(0);          // miss between entries
      find_word(8);

      // Random phases: mostly small tables, some full, some counts past the
      // depth so the count saturates. Binary phases mostly get a sorted
      // fill; the rest run the probe sequence over an unsorted table.
      while (beats_sent < ITEM_TARGET) begin
         roll = $urandom_range(0, 19);
         if (roll == 0)       count_value = 0;
         else if (roll < 13)  count_value = $urandom_range(1, 16);
         else if (roll < 17)  count_value = $urandom_range(17, TABLE_DEPTH);
         else if (roll == 17) count_value = TABLE_DEPTH;
         else if (roll == 18) count_value = $urandom_range(TABLE_DEPTH + 1, 126);
         else                 count_value = 127;
         method      = 1'($urandom_range(0, 1));
         sorted      = (method == METHOD_BINARY) && ($urandom_range(0, 5) != 0);
         quiet_phase = ($urandom_range(0, 4) == 0);
         set_mode(count_value, method);
         fill_table(count_value, sorted);
         repeat ($urandom_range(6, 20)) begin
            // occasional stray write: may land outside the count or break order
            if ($urandom_range(0, 7) == 0)
               store_word($urandom_range(0, TABLE_DEPTH - 1), random_word());
            find_word(pick_key(count_value));
         end
      end

      // Drain: wait out the last result, then watch for strays
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failure_count == 0 && pending_results == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

FILE: sorted_table_search.f
src/sts_pkg.sv
src/sts_ram.sv
src/sts_ctrl.sv
src/sts_dpath.sv
src/sorted_table_search.sv
tb/search_result_checker.sv
tb/tb_sorted_table_search.sv
